[sv/ptt_pkg.sv]
// Package for the periodic timer table: field widths, mode codes and the
// command record passed from the front end to the back end. No dependencies.
package ptt_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int MISC_FIRST_DEF = 8;
    localparam int MISC_LAST_DEF  = 15;
    localparam int ANY_SLOT       = 16;

    typedef enum logic [2:0] {
        MODE_TICK    = 3'd0,
        MODE_START   = 3'd1,
        MODE_STOP    = 3'd2,
        MODE_QUERY   = 3'd3,
        MODE_SUSPEND = 3'd4,
        MODE_RESUME  = 3'd5
    } mode_t;

    // One accepted command, as queued between front and back end
    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] now_ms;
        logic [4:0]  slot_id;
        logic [30:0] reload_ms;
        logic        once;
        logic [7:0]  handler_tag;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic       fired;
        logic [3:0] out_slot;
        logic [7:0] out_handler;
        logic       status;
        logic       is_active;
        logic       last;
    } res_t;

endpackage

[sv/ptt_front.sv]
// Front end of the periodic timer table: two-entry command
// queue. Depends on ptt_pkg.
module ptt_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  ptt_pkg::cmd_t  in_cmd,
    output logic           q_valid,
    input  logic           q_ready,
    output ptt_pkg::cmd_t  q_cmd
);

    ptt_pkg::cmd_t mem_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic          push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Store incoming transaction
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[sv/ptt_back.sv]
// Back end of the periodic timer table: slot store and the walking sequencer
// that executes each command. Depends on ptt_pkg.
module ptt_back #(
    parameter int SLOTS      = ptt_pkg::SLOTS_DEF,
    parameter int MISC_FIRST = ptt_pkg::MISC_FIRST_DEF,
    parameter int MISC_LAST  = ptt_pkg::MISC_LAST_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  ptt_pkg::cmd_t  q_cmd,
    output logic           res_valid,
    input  logic           res_ready,
    output ptt_pkg::res_t  res
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = IW + 1;
    localparam int HI = (MISC_LAST > SLOTS - 1) ? SLOTS - 1 : MISC_LAST;
    localparam logic [CW-1:0] LO_C = CW'(MISC_FIRST);
    localparam logic [CW-1:0] HI_C = CW'(HI);
    localparam logic [CW-1:0] LAST_C = CW'(SLOTS - 1);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_WALK  = 6'b000010,
        ST_FIND  = 6'b000100,
        ST_FREE  = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_FLUSH = 6'b100000
    } state_t;

    state_t        state_reg;
    ptt_pkg::cmd_t cmd_reg;
    logic [CW-1:0] idx_reg;
    logic          found_reg;
    logic          suspended_reg;
    logic [SLOTS-1:0] active_reg;
    logic [31:0]   start_reg   [SLOTS];
    logic [30:0]   delay_reg   [SLOTS];
    logic          once_reg    [SLOTS];
    logic [7:0]    handler_reg [SLOTS];
    ptt_pkg::res_t res_reg;
    logic          res_valid_reg;
    // Result produced by a walk step or a command, waiting for the output register
    ptt_pkg::res_t pend_reg;
    logic          pend_valid_reg;
    // Latest firing of the current walk, held until it is known whether it is the last
    ptt_pkg::res_t hold_reg;
    logic          hold_valid_reg;

    logic [IW-1:0] idx;
    logic [31:0]   elapsed;
    logic          fire;
    logic          slot_ok;
    logic          pend_free;
    logic          pend_drain;
    logic          pend_load;
    ptt_pkg::res_t pend_load_res;
    ptt_pkg::res_t fire_res;

    assign idx       = idx_reg[IW-1:0];
    assign elapsed   = cmd_reg.now_ms - start_reg[idx];
    assign fire      = active_reg[idx] && !elapsed[31] && (elapsed[30:0] > delay_reg[idx]);
    assign slot_ok   = (cmd_reg.slot_id < 5'(SLOTS));
    assign q_ready   = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign pend_free  = !pend_valid_reg || !res_valid_reg || res_ready;
    assign pend_drain = pend_valid_reg && (!res_valid_reg || res_ready);

    // Build the firing result of the current walk step
    always_comb begin
        fire_res             = '0;
        fire_res.fired       = 1'b1;
        fire_res.out_slot    = 4'(idx);
        fire_res.out_handler = handler_reg[idx];
    end

    // Select what enters the pending register this cycle
    always_comb begin
        pend_load     = 1'b0;
        pend_load_res = '0;
        case (state_reg)
            ST_WALK: begin
                if (!suspended_reg && pend_free && fire && hold_valid_reg) begin
                    pend_load     = 1'b1;
                    pend_load_res = hold_reg;
                end
            end
            ST_FLUSH: begin
                if (pend_free && hold_valid_reg) begin
                    pend_load          = 1'b1;
                    pend_load_res      = hold_reg;
                    pend_load_res.last = 1'b1;
                end
            end
            ST_EMIT: begin
                if (pend_free) begin
                    pend_load          = 1'b1;
                    pend_load_res.last = 1'b1;
                    case (cmd_reg.mode)
                        ptt_pkg::MODE_START: begin
                            if (cmd_reg.slot_id == 5'(ptt_pkg::ANY_SLOT)) begin
                                if (found_reg) pend_load_res.out_slot = 4'(idx);
                                else pend_load_res.status = 1'b1;
                            end else if (slot_ok) begin
                                pend_load_res.out_slot = 4'(cmd_reg.slot_id);
                            end else begin
                                pend_load_res.status = 1'b1;
                            end
                        end
                        ptt_pkg::MODE_QUERY: begin
                            pend_load_res.is_active = slot_ok
                                && active_reg[cmd_reg.slot_id[IW-1:0]];
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Output register: load a pending result once free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (!res_valid_reg || res_ready) begin
            res_valid_reg <= pend_valid_reg;
            res_reg       <= pend_reg;
        end
    end

    // Pending register: take a new result or drain into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (pend_load) begin
            pend_valid_reg <= 1'b1;
            pend_reg       <= pend_load_res;
        end else if (pend_drain) begin
            pend_valid_reg <= 1'b0;
        end
    end

    // Command sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            active_reg     <= '0;
            suspended_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        cmd_reg   <= q_cmd;
                        found_reg <= 1'b0;
                        if (q_cmd.mode == ptt_pkg::MODE_TICK) begin
                            idx_reg   <= '0;
                            state_reg <= ST_WALK;
                        end else if (q_cmd.mode == ptt_pkg::MODE_START
                                     && q_cmd.slot_id == 5'(ptt_pkg::ANY_SLOT)) begin
                            idx_reg   <= LO_C;
                            state_reg <= ST_FIND;
                        end else begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                // Walk slots one per cycle while the pending register is free, fire those that are due
                ST_WALK: begin
                    if (suspended_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (pend_free) begin
                        if (fire) begin
                            hold_reg       <= fire_res;
                            hold_valid_reg <= 1'b1;
                            start_reg[idx] <= cmd_reg.now_ms;
                            if (once_reg[idx]) active_reg[idx] <= 1'b0;
                        end
                        if (idx_reg == LAST_C) begin
                            state_reg <= ST_FLUSH;
                        end
                        idx_reg <= idx_reg + ONE_C;
                    end
                end
                // Release the held firing as the final result of the tick
                ST_FLUSH: begin
                    if (!hold_valid_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (pend_free) begin
                        hold_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                // Look for an active misc slot with the same handler
                ST_FIND: begin
                    if (MISC_FIRST > HI) begin
                        state_reg <= ST_EMIT;
                    end else if (active_reg[idx] && handler_reg[idx] == cmd_reg.handler_tag) begin
                        found_reg <= 1'b1;
                        state_reg <= ST_EMIT;
                    end else if (idx_reg == HI_C) begin
                        idx_reg   <= LO_C;
                        state_reg <= ST_FREE;
                    end else begin
                        idx_reg <= idx_reg + ONE_C;
                    end
                end
                // Otherwise take the first free misc slot
                ST_FREE: begin
                    if (!active_reg[idx]) begin
                        found_reg <= 1'b1;
                        state_reg <= ST_EMIT;
                    end else if (idx_reg == HI_C) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        idx_reg <= idx_reg + ONE_C;
                    end
                end
                // Apply the single-result commands
                ST_EMIT: begin
                    if (pend_free) begin
                        state_reg <= ST_IDLE;
                        case (cmd_reg.mode)
                            ptt_pkg::MODE_START: begin
                                if (cmd_reg.slot_id == 5'(ptt_pkg::ANY_SLOT)) begin
                                    if (found_reg) begin
                                        start_reg[idx]   <= cmd_reg.now_ms;
                                        delay_reg[idx]   <= cmd_reg.reload_ms;
                                        once_reg[idx]    <= cmd_reg.once;
                                        handler_reg[idx] <= cmd_reg.handler_tag;
                                        active_reg[idx]  <= 1'b1;
                                    end
                                end else if (slot_ok) begin
                                    start_reg[cmd_reg.slot_id[IW-1:0]]   <= cmd_reg.now_ms;
                                    delay_reg[cmd_reg.slot_id[IW-1:0]]   <= cmd_reg.reload_ms;
                                    once_reg[cmd_reg.slot_id[IW-1:0]]    <= cmd_reg.once;
                                    handler_reg[cmd_reg.slot_id[IW-1:0]] <= cmd_reg.handler_tag;
                                    active_reg[cmd_reg.slot_id[IW-1:0]]  <= 1'b1;
                                end
                            end
                            ptt_pkg::MODE_STOP: begin
                                if (slot_ok) active_reg[cmd_reg.slot_id[IW-1:0]] <= 1'b0;
                            end
                            ptt_pkg::MODE_SUSPEND: suspended_reg <= 1'b1;
                            ptt_pkg::MODE_RESUME: begin
                                for (int i = 0; i < SLOTS; i++) begin
                                    if (active_reg[i]) start_reg[i] <= cmd_reg.now_ms;
                                end
                                suspended_reg <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[sv/periodic_timer_table.sv]
// Periodic timer table. Each command is one transaction on the s_ stream and
// its results leave on the m_ stream, m_tlast marking the final result of the
// command. A tick walks all SLOTS slots one per cycle, pausing while the pending
// register cannot take a result, and returns one result per firing slot, none
// when nothing fires or the table is suspended; every other command returns
// exactly one result. A start to any slot searches the misc range for an active
// slot with the same handler, then for a free one. Each firing is held until the
// next one or the end of the walk so that its last flag is known. A two-entry
// queue keeps s_tready high while the back end works; a stalled receiver fills
// the output register, one pending result and the queue before s_tready drops.
// Top level: front end queue plus back end walker.
// Depends on ptt_pkg, ptt_front, ptt_back.
module periodic_timer_table #(
    parameter int SLOTS      = ptt_pkg::SLOTS_DEF,
    parameter int MISC_FIRST = ptt_pkg::MISC_FIRST_DEF,
    parameter int MISC_LAST  = ptt_pkg::MISC_LAST_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mode[2:0], now_ms[34:3], slot_id[39:35], reload_ms[70:40], once[71], handler_tag[79:72]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // fired[0], out_slot[4:1], out_handler[12:5], status[13], is_active[14]
    output logic [15:0] m_tdata,
    output logic        m_tlast
);
    ptt_pkg::cmd_t in_cmd, q_cmd;
    ptt_pkg::res_t res;
    logic q_valid, q_ready;

    assign in_cmd = '{mode: s_tdata[2:0], now_ms: s_tdata[34:3], slot_id: s_tdata[39:35],
                      reload_ms: s_tdata[70:40], once: s_tdata[71],
                      handler_tag: s_tdata[79:72]};

    ptt_front u_front (.aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
                       .in_cmd, .q_valid, .q_ready, .q_cmd);

    ptt_back #(.SLOTS(SLOTS), .MISC_FIRST(MISC_FIRST), .MISC_LAST(MISC_LAST)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .res_valid(m_tvalid), .res_ready(m_tready), .res);

    assign m_tdata = {1'b0, res.is_active, res.status, res.out_handler, res.out_slot, res.fired};
    assign m_tlast = res.last;
endmodule

[verif/periodic_timer_table_test.sv]
// Self-checking testbench for the periodic timer table: directed command table
// followed by random command sequences, checked against a behavioral predictor.
// Depends on ptt_pkg and periodic_timer_table.
`timescale 1ns / 1ps

module periodic_timer_table_test;

    localparam int NSLOT      = 16;
    localparam int MISC_LO    = 8;
    localparam int MISC_HI    = 15;
    localparam int MAX_CYCLES = 400000;
    localparam logic [2:0] MODE_BAD6 = 3'd6;
    localparam logic [2:0] MODE_BAD7 = 3'd7;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic       fired;
        logic [3:0] slot;
        logic [7:0] handler;
        logic       status;
        logic       active;
        logic       last;
    } timer_res_t;

    // one directed row: command plus optional fixed expectation
    typedef struct {
        ptt_pkg::cmd_t cmd;
        bit            fixed;
        timer_res_t    res;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    periodic_timer_table u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    // predictor state
    bit          tbl_active [NSLOT];
    logic [31:0] tbl_start [NSLOT];
    logic [30:0] tbl_delay [NSLOT];
    bit          tbl_once [NSLOT];
    logic [7:0]  tbl_handler [NSLOT];
    bit          tbl_held;

    timer_res_t  pending_res[$];
    int          errors = 0;
    int          results_seen = 0;
    int          fires_seen = 0;
    int          cycles = 0;
    bit          stall_on = 0;
    bit          no_idle = 0;
    bit          long_hold = 0;

    function automatic timer_res_t mk(logic f, logic [3:0] s, logic [7:0] h,
                                      logic st, logic a);
        timer_res_t r;
        r.fired = f; r.slot = s; r.handler = h; r.status = st; r.active = a;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void arm(int s, ptt_pkg::cmd_t c);
        tbl_active[s] = 1; tbl_start[s] = c.now_ms; tbl_delay[s] = c.reload_ms;
        tbl_once[s] = c.once; tbl_handler[s] = c.handler_tag;
    endfunction

    // compute results of one command and advance the table
    function automatic void predict_timers(ptt_pkg::cmd_t c);
        timer_res_t r;
        logic [31:0] el;
        int first;
        bit done;
        first = pending_res.size();
        case (c.mode)
            ptt_pkg::MODE_TICK: begin
                if (!tbl_held) begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (!tbl_active[i]) continue;
                        el = c.now_ms - tbl_start[i];
                        if (!el[31] && el > {1'b0, tbl_delay[i]}) begin
                            r = mk(1'b1, i[3:0], tbl_handler[i], STATUS_OK, 1'b0);
                            r.last = 1'b0;
                            pending_res.push_back(r);
                            tbl_start[i] = c.now_ms;
                            if (tbl_once[i]) tbl_active[i] = 0;
                        end
                    end
                    if (pending_res.size() > first)
                        pending_res[pending_res.size() - 1].last = 1'b1;
                end
            end
            ptt_pkg::MODE_START: begin
                if (c.slot_id == ptt_pkg::ANY_SLOT) begin
                    done = 0;
                    for (int i = MISC_LO; i <= MISC_HI && !done; i++)
                        if (tbl_active[i] && tbl_handler[i] == c.handler_tag) begin
                            tbl_start[i] = c.now_ms; tbl_delay[i] = c.reload_ms;
                            tbl_once[i] = c.once; done = 1;
                            pending_res.push_back(mk(0, i[3:0], 0, STATUS_OK, 0));
                        end
                    for (int i = MISC_LO; i <= MISC_HI && !done; i++)
                        if (!tbl_active[i]) begin
                            arm(i, c); done = 1;
                            pending_res.push_back(mk(0, i[3:0], 0, STATUS_OK, 0));
                        end
                    if (!done) pending_res.push_back(mk(0, 0, 0, STATUS_FULL, 0));
                end else if (c.slot_id < NSLOT) begin
                    arm(c.slot_id, c);
                    pending_res.push_back(mk(0, c.slot_id[3:0], 0, STATUS_OK, 0));
                end else begin
                    pending_res.push_back(mk(0, 0, 0, STATUS_FULL, 0));
                end
            end
            ptt_pkg::MODE_QUERY:
                pending_res.push_back(mk(0, 0, 0, STATUS_OK,
                    (c.slot_id < NSLOT) ? tbl_active[c.slot_id] : 1'b0));
            default: begin
                if (c.mode == ptt_pkg::MODE_STOP && c.slot_id < NSLOT)
                    tbl_active[c.slot_id] = 0;
                if (c.mode == ptt_pkg::MODE_SUSPEND) tbl_held = 1;
                if (c.mode == ptt_pkg::MODE_RESUME) begin
                    for (int i = 0; i < NSLOT; i++)
                        if (tbl_active[i]) tbl_start[i] = c.now_ms;
                    tbl_held = 0;
                end
                pending_res.push_back(mk(0, 0, 0, STATUS_OK, 0));
            end
        endcase
    endfunction

    // send one command transaction, idling at random beforehand
    task automatic send_cmd(ptt_pkg::cmd_t c);
        if (!no_idle && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while (!no_idle && $urandom_range(99) < 38) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {c.handler_tag, c.once, c.reload_ms, c.slot_id, c.now_ms, c.mode};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_row(row_t r);
        int first;
        first = pending_res.size();
        predict_timers(r.cmd);
        if (r.fixed && (pending_res.size() != first + 1 || pending_res[first] != r.res)) begin
            $error("directed row mismatch: expected %h", r.res);
            errors++;
        end
        send_cmd(r.cmd);
    endtask

    function automatic ptt_pkg::cmd_t cm(logic [2:0] m, logic [31:0] t, logic [4:0] s,
                                         logic [30:0] d, logic o, logic [7:0] h);
        ptt_pkg::cmd_t c;
        c.mode = m; c.now_ms = t; c.slot_id = s; c.reload_ms = d; c.once = o;
        c.handler_tag = h;
        return c;
    endfunction

    function automatic row_t rw(ptt_pkg::cmd_t c, bit f, timer_res_t r);
        row_t x;
        x.cmd = c; x.fixed = f; x.res = r;
        return x;
    endfunction

    // random command; slot ids biased toward valid slots and "any"
    function automatic ptt_pkg::cmd_t rand_cmd(ref logic [31:0] clk_ms);
        ptt_pkg::cmd_t c;
        int p;
        p = $urandom_range(99);
        c.now_ms = clk_ms;
        c.slot_id = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                  : ($urandom_range(3) == 0) ? 5'(ptt_pkg::ANY_SLOT) : 5'($urandom_range(15));
        c.reload_ms = ($urandom_range(7) == 0) ? 31'($urandom) : 31'($urandom_range(20));
        c.once = 1'($urandom_range(1));
        c.handler_tag = ($urandom_range(1)) ? 8'($urandom_range(3)) : 8'($urandom);
        if (p < 45) begin
            c.mode = ptt_pkg::MODE_TICK;
            clk_ms = clk_ms + $urandom_range(8);
            c.now_ms = clk_ms;
        end else if (p < 70) c.mode = ptt_pkg::MODE_START;
        else if (p < 78) c.mode = ptt_pkg::MODE_STOP;
        else if (p < 88) c.mode = ptt_pkg::MODE_QUERY;
        else if (p < 92) c.mode = ptt_pkg::MODE_SUSPEND;
        else if (p < 97) c.mode = ptt_pkg::MODE_RESUME;
        else c.mode = ($urandom_range(1)) ? MODE_BAD6 : MODE_BAD7;
        return c;
    endfunction

    // check each result transaction against the oldest expectation
    always @(posedge aclk) begin
        timer_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[0], m_tdata[4:1], m_tdata[12:5], m_tdata[13], m_tdata[14],
                   m_tlast};
            results_seen++;
            if (got.fired) fires_seen++;
            if (pending_res.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
            end else begin
                want = pending_res.pop_front();
                if (got.fired != want.fired) begin
                    $error("fired: expected %0d, actual %0d", want.fired, got.fired); errors++;
                end
                if (got.slot != want.slot) begin
                    $error("out_slot: expected %0d, actual %0d", want.slot, got.slot); errors++;
                end
                if (got.handler != want.handler) begin
                    $error("out_handler: expected %0d, actual %0d", want.handler,
                           got.handler); errors++;
                end
                if (got.status != want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    errors++;
                end
                if (got.active != want.active) begin
                    $error("is_active: expected %0d, actual %0d", want.active, got.active);
                    errors++;
                end
                if (got.last != want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, got.last); errors++;
                end
            end
        end
    end

    // drive receiver ready: random stalls, long hold-off on request
    always @(posedge aclk) begin
        if (long_hold) m_tready <= 1'b0;
        else if (no_idle) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(99) >= 38);
    end

    // hold off the receiver for a long stretch
    initial begin
        wait (stall_on);
        long_hold = 1;
        repeat (300) @(posedge aclk);
        long_hold = 0;
    end

    // cycle limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("periodic_timer_table_test failed");
            $finish;
        end
    end

    initial begin
        row_t        rows[$];
        logic [31:0] clk_ms;
        int          wait_n;
        for (int i = 0; i < NSLOT; i++) begin
            tbl_active[i] = 0; tbl_start[i] = '0; tbl_delay[i] = '0;
            tbl_once[i] = 0; tbl_handler[i] = '0;
        end
        tbl_held = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        rows.push_back(rw(cm(ptt_pkg::MODE_QUERY, 0, 0, 0, 0, 0), 1,
                          mk(0, 0, 0, STATUS_OK, 0)));
        rows.push_back(rw(cm(ptt_pkg::MODE_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0), 0, '0));
        rows.push_back(rw(cm(ptt_pkg::MODE_START, 32'hFFFF_FFF0, 0, 31'h7FFF_FFFF, 1, 8'hFF),
                          1, mk(0, 0, 0, STATUS_OK, 0)));
        rows.push_back(rw(cm(ptt_pkg::MODE_START, 32'hFFFF_FFF0, 15, 0, 0, 8'hA5), 1,
                          mk(0, 15, 0, STATUS_OK, 0)));
        rows.push_back(rw(cm(ptt_pkg::MODE_TICK, 32'h0000_0005, 0, 0, 0, 0), 0, '0));
        rows.push_back(rw(cm(ptt_pkg::MODE_QUERY, 0, 15, 0, 0, 0), 1,
                          mk(0, 0, 0, STATUS_OK, 1)));
        rows.push_back(rw(cm(ptt_pkg::MODE_QUERY, 0, 31, 0, 0, 0), 1,
                          mk(0, 0, 0, STATUS_OK, 0)));
        rows.push_back(rw(cm(ptt_pkg::MODE_START, 0, 20, 5, 0, 1), 1,
                          mk(0, 0, 0, STATUS_FULL, 0)));
        rows.push_back(rw(cm(ptt_pkg::MODE_STOP, 0, 31, 0, 0, 0), 1,
                          mk(0, 0, 0, STATUS_OK, 0)));
        rows.push_back(rw(cm(ptt_pkg::MODE_STOP, 0, 0, 0, 0, 0), 1,
                          mk(0, 0, 0, STATUS_OK, 0)));
        for (int i = 0; i < 7; i++)
            rows.push_back(rw(cm(ptt_pkg::MODE_START, 10, 5'(ptt_pkg::ANY_SLOT), 2, i[0],
                                 8'(i + 1)), 0, '0));
        rows.push_back(rw(cm(ptt_pkg::MODE_START, 11, 5'(ptt_pkg::ANY_SLOT), 3, 1, 8'd1), 1,
                          mk(0, 8, 0, STATUS_OK, 0)));
        rows.push_back(rw(cm(ptt_pkg::MODE_START, 12, 5'(ptt_pkg::ANY_SLOT), 3, 0, 8'd99), 1,
                          mk(0, 0, 0, STATUS_FULL, 0)));
        rows.push_back(rw(cm(ptt_pkg::MODE_SUSPEND, 13, 0, 0, 0, 0), 1,
                          mk(0, 0, 0, STATUS_OK, 0)));
        rows.push_back(rw(cm(ptt_pkg::MODE_TICK, 100, 0, 0, 0, 0), 0, '0));
        rows.push_back(rw(cm(ptt_pkg::MODE_START, 100, 3, 1, 0, 8'h3C), 0, '0));
        rows.push_back(rw(cm(ptt_pkg::MODE_RESUME, 200, 0, 0, 0, 0), 1,
                          mk(0, 0, 0, STATUS_OK, 0)));
        rows.push_back(rw(cm(ptt_pkg::MODE_TICK, 210, 0, 0, 0, 0), 0, '0));
        rows.push_back(rw(cm(MODE_BAD6, 0, 0, 0, 0, 0), 1, mk(0, 0, 0, STATUS_OK, 0)));
        rows.push_back(rw(cm(MODE_BAD7, 32'hFFFF_FFFF, 5'h1F, 31'h7FFF_FFFF, 1, 8'hFF), 1,
                          mk(0, 0, 0, STATUS_OK, 0)));
        foreach (rows[i]) send_row(rows[i]);

        // random part; back-to-back stretch, then receiver hold-off
        clk_ms = 32'd300;
        for (int n = 0; n < 75; n++) begin
            if (n == 20) no_idle = 1;
            if (n == 45) no_idle = 0;
            if (n == 60) stall_on = 1;
            if ($urandom_range(49) == 0) clk_ms = clk_ms + 32'h8000_0000;
            send_row(rw(rand_cmd(clk_ms), 0, '0));
        end
        s_tvalid <= 1'b0;

        wait_n = 0;
        while (pending_res.size() != 0 && wait_n < 100000) begin
            @(posedge aclk);
            wait_n++;
        end
        repeat (100) @(posedge aclk);
        $display("Covered all modes, named and any-slot starts, full misc range, suspend,");
        $display("resume and wrapped times: %0d results, %0d firings.", results_seen,
                 fires_seen);
        if (errors == 0 && pending_res.size() == 0)
            $display("periodic_timer_table_test passed");
        else
            $display("periodic_timer_table_test failed");
        $finish;
    end
endmodule
